>>> hdl/cdq_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package cdq_pkg;

  localparam int unsigned VALUE_W = 32;
  localparam int unsigned CAP_W   = 5;
  localparam int unsigned MODE_W  = 2;

  typedef enum logic [MODE_W-1:0] {
    MODE_PUSH_FRONT = 2'd0,
    MODE_PUSH_BACK  = 2'd1,
    MODE_POP_FRONT  = 2'd2,
    MODE_POP_BACK   = 2'd3
  } mode_t;

  // Broadcast control to every cell of the chain; at most one field is set.
  typedef struct packed {
    logic flush;
    logic push_front;
    logic push_back;
    logic pop_front;
    logic pop_back;
  } cell_ctl_t;

endpackage
`default_nettype wire

>>> hdl/circular_deque_core.sv
`timescale 1ns / 1ps
`default_nettype none
// Double-ended queue of configurable capacity held in a chain of DEPTH cells.
// The result of a request appears with done in the cycle after start.
// Throughput: one request per cycle; busy is never raised, the cell chain
// updates every entry together.
// Reset (synchronous, active high) empties the deque and sets capacity to 16.
// The receiver cannot stall: each result is shown for exactly one cycle.
module circular_deque_core #(
  parameter int unsigned DEPTH = 16
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         start,
  output logic                              busy,
  input  wire logic [cdq_pkg::MODE_W-1:0]   mode,
  input  wire logic [cdq_pkg::VALUE_W-1:0]  value,
  input  wire logic                         cfg_we,
  input  wire logic [cdq_pkg::CAP_W-1:0]    cfg_wdata,
  output logic                              done,
  output logic                              accepted,
  output logic      [cdq_pkg::VALUE_W-1:0]  front_value,
  output logic      [cdq_pkg::VALUE_W-1:0]  rear_value,
  output logic                              is_empty,
  output logic                              is_full
);
  import cdq_pkg::*;

  // Width that holds both the capacity register and DEPTH itself.
  localparam int unsigned DW = $clog2(DEPTH + 1);
  localparam int unsigned CW = ((DW > CAP_W) ? DW : CAP_W) + 1;

  // The deque always occupies cells 0 up to count-1, with the front entry in
  // cell 0. A push at the front shifts the chain one cell right, a pop at the
  // front shifts it one cell left, and the back end is the last valid cell,
  // so only a push or pop at the back acts at a position that depends on the fill.
  logic [CAP_W-1:0]           capacity;
  logic [CW-1:0]              cap_ext;
  logic [CW-1:0]              eff_cap;
  logic [DEPTH-1:0]           cell_valid;
  logic [DEPTH-1:0]           cell_tail;
  logic [DEPTH-1:0]           cell_last;
  logic [VALUE_W-1:0]         cell_data [DEPTH];
  logic                       full_now;
  logic                       take;
  logic                       ok;
  cell_ctl_t                  ctl;
  logic [VALUE_W-1:0]         rear_or;

  // A busy phase is never needed, since the chain completes every request it takes.
  assign busy = 1'b0;
  assign take = start && !busy;

  // Capacity zero behaves as one, and values above the built depth clamp to it.
  assign cap_ext = CW'(capacity);
  always_comb begin
    if (cap_ext == '0) begin
      eff_cap = CW'(1);
    end else if (cap_ext > CW'(DEPTH)) begin
      eff_cap = CW'(DEPTH);
    end else begin
      eff_cap = cap_ext;
    end
  end

  for (genvar i = 0; i < DEPTH; i++) begin : g_last
    assign cell_last[i] = (eff_cap == CW'(i + 1));
  end

  // The deque is full when the cell at the capacity boundary is occupied.
  assign full_now = |(cell_valid & cell_last);

  // Decide whether the request goes through and steer the cells accordingly.
  always_comb begin
    ok  = 1'b0;
    ctl = '0;
    if (cfg_we) begin
      ctl.flush = 1'b1;
    end else if (take) begin
      unique case (mode_t'(mode))
        MODE_PUSH_FRONT: begin
          ok             = !full_now;
          ctl.push_front = !full_now;
        end
        MODE_PUSH_BACK: begin
          ok            = !full_now;
          ctl.push_back = !full_now;
        end
        MODE_POP_FRONT: begin
          ok            = cell_valid[0];
          ctl.pop_front = cell_valid[0];
        end
        MODE_POP_BACK: begin
          ok           = cell_valid[0];
          ctl.pop_back = cell_valid[0];
        end
        default: begin
          ok = 1'b0;
        end
      endcase
    end
  end

  // The chain of cells; cell 0 sees the pushed word as its left neighbor,
  // and the cell past the end reads as an empty slot.
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [VALUE_W-1:0] l_data;
    logic               l_valid;
    logic [VALUE_W-1:0] r_data;
    logic               r_valid;

    if (i == 0) begin : g_head
      assign l_data  = value;
      assign l_valid = 1'b1;
    end else begin : g_mid
      assign l_data  = cell_data[i-1];
      assign l_valid = cell_valid[i-1];
    end

    if (i == DEPTH - 1) begin : g_end
      assign r_data  = '0;
      assign r_valid = 1'b0;
    end else begin : g_inner
      assign r_data  = cell_data[i+1];
      assign r_valid = cell_valid[i+1];
    end

    cdq_cell u_cell (
      .clk         (clk),
      .rst         (rst),
      .ctl         (ctl),
      .push_value  (value),
      .left_data   (l_data),
      .left_valid  (l_valid),
      .right_data  (r_data),
      .right_valid (r_valid),
      .data        (cell_data[i]),
      .valid       (cell_valid[i]),
      .tail        (cell_tail[i])
    );
  end

  // At most one cell flags itself as the tail, so an OR of masked words
  // selects the rear entry.
  always_comb begin
    rear_or = '0;
    for (int i = 0; i < DEPTH; i++) begin
      rear_or = rear_or | (cell_data[i] & {VALUE_W{cell_tail[i]}});
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      capacity <= CAP_W'(16);
      done     <= 1'b0;
      accepted <= 1'b0;
    end else begin
      if (cfg_we) begin
        capacity <= cfg_wdata;
      end
      done     <= take;
      accepted <= ok;
    end
  end

  // The result fields come straight from the chain, which already holds the
  // state left by the request that done reports on.
  assign is_empty    = !cell_valid[0];
  assign is_full     = full_now;
  assign front_value = cell_valid[0] ? cell_data[0] : '1;
  assign rear_value  = cell_valid[0] ? rear_or : '1;

  a_done_follows: assert property (@(posedge clk) disable iff (rst)
    take |=> done)
    else $error("request was not answered in the next cycle");

  a_single_tail: assert property (@(posedge clk) disable iff (rst)
    $onehot0(cell_tail))
    else $error("more than one rear entry in the chain");

  a_empty_sentinel: assert property (@(posedge clk) disable iff (rst)
    done && is_empty |-> (front_value == '1) && (rear_value == '1) && !is_full)
    else $error("empty deque reports data or full");

  a_flush_clears: assert property (@(posedge clk) disable iff (rst)
    cfg_we |=> !cell_valid[0])
    else $error("capacity write left entries in the deque");

endmodule
`default_nettype wire

>>> hdl/cdq_cell.sv
`timescale 1ns / 1ps
`default_nettype none
module cdq_cell (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire cdq_pkg::cell_ctl_t           ctl,
  input  wire logic [cdq_pkg::VALUE_W-1:0]  push_value,
  input  wire logic [cdq_pkg::VALUE_W-1:0]  left_data,
  input  wire logic                         left_valid,
  input  wire logic [cdq_pkg::VALUE_W-1:0]  right_data,
  input  wire logic                         right_valid,
  output logic      [cdq_pkg::VALUE_W-1:0]  data,
  output logic                              valid,
  output logic                              tail
);
  import cdq_pkg::*;

  logic                 valid_next;
  logic [VALUE_W-1:0]   data_next;

  // The rear entry is the last valid cell of the chain.
  assign tail = valid && !right_valid;

  always_comb begin
    valid_next = valid;
    data_next  = data;
    if (ctl.flush) begin
      valid_next = 1'b0;
    end else if (ctl.push_front) begin
      valid_next = left_valid;
      data_next  = left_data;
    end else if (ctl.pop_front) begin
      valid_next = right_valid;
      data_next  = right_data;
    end else if (ctl.push_back) begin
      if (!valid && left_valid) begin
        valid_next = 1'b1;
        data_next  = push_value;
      end
    end else if (ctl.pop_back) begin
      if (tail) begin
        valid_next = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else begin
      valid <= valid_next;
    end
    data <= data_next;
  end

endmodule
`default_nettype wire
